// ===== rtl/emt_pkg.sv =====
// ----------------------------------------------------------------------------
// emt_pkg
// shared types, codes and defaults for the extent map table
// ----------------------------------------------------------------------------
package emt_pkg;

  localparam int DefMaxExtents = 64;

  localparam logic [1:0] ActLookup = 2'd0;
  localparam logic [1:0] ActCreate = 2'd1;
  localparam logic [1:0] ActClear  = 2'd2;
  localparam logic [1:0] ActSet    = 2'd3;

  localparam logic [2:0] StHit      = 3'd0;
  localparam logic [2:0] StMapped   = 3'd1;
  localparam logic [2:0] StUnmapped = 3'd2;
  localparam logic [2:0] StNoBlock  = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StDone     = 3'd5;
  localparam logic [2:0] StBadLen   = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] logical_block;
    logic [15:0] physical_in;
    logic        alloc_ok;
    logic [15:0] run_length;
  } in_t;

  typedef struct packed {
    logic [15:0] physical_block;
    logic [2:0]  status;
    logic [6:0]  extents_used;
  } out_t;

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] phys;
    logic [15:0] len;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_EXTEND,
    OP_INSERT,
    OP_MERGE
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_INSERT,
    S_MERGE,
    S_RESP
  } state_e;

  // flags rippling along the row of cells
  typedef struct packed {
    logic ins_found;
    logic mrg_found;
  } chain_t;

endpackage

// ===== rtl/emt_cell.sv =====
// ----------------------------------------------------------------------------
// emt_cell
// one table slot: holds an extent and trades it with its neighbors
// ----------------------------------------------------------------------------
module emt_cell #(
  parameter int MaxExtents = emt_pkg::DefMaxExtents,
  parameter int Idx        = 0
) (
  input  logic                             clk_i,
  input  emt_pkg::op_e                     op_i,
  input  logic [$clog2(MaxExtents+1)-1:0]  count_i,
  input  emt_pkg::in_t                     item_i,
  input  emt_pkg::entry_t                  left_i,
  input  emt_pkg::entry_t                  right_i,
  input  emt_pkg::chain_t                  chain_i,
  output emt_pkg::chain_t                  chain_o,
  input  logic                             hit_i,
  input  logic [15:0]                      hit_phys_i,
  output logic                             hit_o,
  output logic [15:0]                      hit_phys_o,
  output emt_pkg::entry_t                  entry_o
);

  localparam int CW = $clog2(MaxExtents+1);
  localparam logic [CW:0] IdxW = (CW+1)'(Idx);

  emt_pkg::entry_t entry_q, entry_d;
  logic        valid, next_valid, at_count;
  logic        hit_here, ins_here, adj_here;
  logic [31:0] end_l;
  logic [16:0] end_p;

  assign valid      = {1'b0, count_i} > IdxW;
  assign next_valid = {1'b0, count_i} > (IdxW + 1'b1);
  assign at_count   = {1'b0, count_i} == IdxW;

  assign end_l = entry_q.start + {16'd0, entry_q.len};
  assign end_p = {1'b0, entry_q.phys} + {1'b0, entry_q.len};

  // coverage, highest index wins
  assign hit_here   = valid && (entry_q.len != 16'd0) &&
                      (item_i.logical_block >= entry_q.start) &&
                      (item_i.logical_block < end_l);
  assign hit_o      = hit_i | hit_here;
  assign hit_phys_o = hit_i ? hit_phys_i :
                      entry_q.phys + 16'(item_i.logical_block - entry_q.start);

  assign ins_here = valid && (item_i.logical_block < entry_q.start);
  assign adj_here = next_valid && (end_l == right_i.start) &&
                    (end_p == {1'b0, right_i.phys});

  assign chain_o.ins_found = chain_i.ins_found | ins_here;
  assign chain_o.mrg_found = chain_i.mrg_found | adj_here;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      emt_pkg::OP_SET: begin
        if (Idx == 0) begin
          entry_d.start = item_i.logical_block;
          entry_d.phys  = item_i.physical_in;
          entry_d.len   = item_i.run_length;
        end
      end
      emt_pkg::OP_EXTEND: begin
        if (Idx == 0) entry_d.len = entry_q.len + 16'd1;
      end
      emt_pkg::OP_INSERT: begin
        if (chain_i.ins_found && (valid || at_count)) begin
          entry_d = left_i;
        end else if (!chain_i.ins_found && (ins_here || at_count)) begin
          entry_d.start = item_i.logical_block;
          entry_d.phys  = item_i.physical_in;
          entry_d.len   = 16'd1;
        end
      end
      emt_pkg::OP_MERGE: begin
        if (!chain_i.mrg_found && adj_here) begin
          entry_d.len = entry_q.len + right_i.len;
        end else if (chain_i.mrg_found && next_valid) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/extent_map_table_top.sv =====
// ----------------------------------------------------------------------------
// extent_map_table_top
// sorted extent table built as a row of cells with a small sequencer
// ----------------------------------------------------------------------------
// One item is handled at a time. A lookup, a miss, a clear, a set-single or
// an extension of the single extent goes through accept, table compare and
// the result register. A create that inserts a new extent adds an insert
// shift, then one merge step per adjacent pair found, then a final check.
// The row of cells does all compares in parallel; insert shifts one slot
// right and each merge shifts one slot left, one whole-row step per cycle.
// A new item is taken once the previous one has reached the output register,
// even while that result waits.
// ----------------------------------------------------------------------------
module extent_map_table_top #(
  parameter int MaxExtents = emt_pkg::DefMaxExtents
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  emt_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output emt_pkg::out_t out_item_o
);

  localparam int CW = $clog2(MaxExtents+1);
  localparam logic [CW-1:0] MaxW = CW'(MaxExtents);

  emt_pkg::state_e state_q, state_d;
  emt_pkg::op_e    op;
  emt_pkg::in_t    item_q;
  logic [CW-1:0]   count_q, count_d;
  logic [15:0]     res_phys_q, res_phys_d;
  logic [2:0]      res_st_q, res_st_d;
  logic            out_valid_q;
  emt_pkg::out_t   out_q;

  // row wiring
  emt_pkg::entry_t entries [MaxExtents];
  emt_pkg::chain_t chain   [MaxExtents+1];
  logic            hit     [MaxExtents+1];
  logic [15:0]     hphys   [MaxExtents+1];

  assign chain[0] = '0;
  assign hit[MaxExtents]   = 1'b0;
  assign hphys[MaxExtents] = 16'd0;

  for (genvar g = 0; g < MaxExtents; g++) begin : g_cell
    emt_pkg::entry_t left_e, right_e;
    if (g == 0) begin : g_l0
      assign left_e = '0;
    end else begin : g_l
      assign left_e = entries[g-1];
    end
    if (g == MaxExtents-1) begin : g_rn
      assign right_e = '0;
    end else begin : g_r
      assign right_e = entries[g+1];
    end
    emt_cell #(.MaxExtents(MaxExtents), .Idx(g)) u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .count_i   (count_q),
      .item_i    (item_q),
      .left_i    (left_e),
      .right_i   (right_e),
      .chain_i   (chain[g]),
      .chain_o   (chain[g+1]),
      .hit_i     (hit[g+1]),
      .hit_phys_i(hphys[g+1]),
      .hit_o     (hit[g]),
      .hit_phys_o(hphys[g]),
      .entry_o   (entries[g])
    );
  end

  logic merge_any, extend_ok;
  emt_pkg::entry_t e0;
  assign e0        = entries[0];
  assign merge_any = chain[MaxExtents].mrg_found;
  // extension of the single extent, both logically and physically contiguous
  assign extend_ok = (count_q == CW'(1)) &&
                     (item_q.logical_block == e0.start + {16'd0, e0.len}) &&
                     (item_q.physical_in == e0.phys + e0.len);

  assign in_ready_o = (state_q == emt_pkg::S_IDLE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    op         = emt_pkg::OP_NONE;
    count_d    = count_q;
    res_phys_d = res_phys_q;
    res_st_d   = res_st_q;
    unique case (state_q)
      emt_pkg::S_IDLE: begin
        if (in_valid_i) state_d = emt_pkg::S_LOOK;
      end
      emt_pkg::S_LOOK: begin
        res_phys_d = 16'd0;
        state_d    = emt_pkg::S_RESP;
        if (item_q.action == emt_pkg::ActClear) begin
          count_d  = '0;
          res_st_d = emt_pkg::StDone;
        end else if (item_q.action == emt_pkg::ActSet) begin
          if (item_q.run_length == 16'd0) begin
            res_st_d = emt_pkg::StBadLen;
          end else begin
            op       = emt_pkg::OP_SET;
            count_d  = CW'(1);
            res_st_d = emt_pkg::StDone;
          end
        end else if (hit[0]) begin
          res_phys_d = hphys[0];
          res_st_d   = emt_pkg::StHit;
        end else if (item_q.action == emt_pkg::ActLookup) begin
          res_st_d = emt_pkg::StUnmapped;
        end else if (!item_q.alloc_ok) begin
          res_st_d = emt_pkg::StNoBlock;
        end else if (extend_ok) begin
          op         = emt_pkg::OP_EXTEND;
          res_phys_d = item_q.physical_in;
          res_st_d   = emt_pkg::StMapped;
        end else if (count_q >= MaxW) begin
          res_st_d = emt_pkg::StFull;
        end else begin
          res_phys_d = item_q.physical_in;
          res_st_d   = emt_pkg::StMapped;
          state_d    = emt_pkg::S_INSERT;
        end
      end
      emt_pkg::S_INSERT: begin
        op      = emt_pkg::OP_INSERT;
        count_d = count_q + 1'b1;
        state_d = emt_pkg::S_MERGE;
      end
      emt_pkg::S_MERGE: begin
        if (merge_any) begin
          op      = emt_pkg::OP_MERGE;
          count_d = count_q - 1'b1;
        end else begin
          state_d = emt_pkg::S_RESP;
        end
      end
      emt_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = emt_pkg::S_IDLE;
      end
      default: state_d = emt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= emt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == emt_pkg::S_RESP && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_item_i;
    res_phys_q <= res_phys_d;
    res_st_q   <= res_st_d;
    if (state_q == emt_pkg::S_RESP && (!out_valid_q || out_ready_i)) begin
      out_q.physical_block <= res_phys_q;
      out_q.status         <= res_st_q;
      out_q.extents_used   <= 7'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // table never grows past its capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxW) else $error("extent count above capacity");

  // an accepted item always goes to the compare step next
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == emt_pkg::S_LOOK)
    else $error("accepted item not looked up");

  // merging stops only when no adjacent pair is left
  a_merge_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == emt_pkg::S_MERGE && !merge_any) |=> state_q == emt_pkg::S_RESP)
    else $error("merge loop did not finish");

  // insert always grows the table by one
  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == emt_pkg::S_INSERT |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow table");
`endif

endmodule

// ===== tb/sv/tb_extent_map_table_top.sv =====
// ----------------------------------------------------------------------------
// tb_extent_map_table_top
// random and directed check of the extent map table against a local model
// ----------------------------------------------------------------------------
// Items go in through a queue-fed driver with random gaps. Each accepted item
// updates a local copy of the extent table and pushes the expected result,
// and a monitor with random stalls compares every result field by field.
// ----------------------------------------------------------------------------
module tb_extent_map_table_top;

  localparam int NumExt = emt_pkg::DefMaxExtents;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  emt_pkg::in_t  in_item;
  logic          out_valid;
  logic          out_ready;
  emt_pkg::out_t out_item;

  extent_map_table_top #(
    .MaxExtents(NumExt)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // local copy of the table
  logic [31:0] tbl_start[NumExt];
  logic [15:0] tbl_phys[NumExt];
  logic [15:0] tbl_len[NumExt];
  int          tbl_count;

  emt_pkg::in_t  pending_items[$];
  emt_pkg::out_t expected_results[$];
  int            mismatches;
  int            results_seen;
  int            sent_items;
  bit            stim_done;

  // fold together neighbours that line up both logically and physically
  function automatic void merge_runs();
    bit          changed;
    logic [31:0] end_l;
    logic [16:0] end_p;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i + 1 < tbl_count; i++) begin
        end_l = tbl_start[i] + 32'(tbl_len[i]);
        end_p = 17'(tbl_phys[i]) + 17'(tbl_len[i]);
        if (end_l == tbl_start[i+1] && end_p == 17'(tbl_phys[i+1])) begin
          tbl_len[i] = tbl_len[i] + tbl_len[i+1];
          for (int k = i + 1; k + 1 < tbl_count; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_phys[k]  = tbl_phys[k+1];
            tbl_len[k]   = tbl_len[k+1];
          end
          tbl_count--;
          changed = 1'b1;
          break;
        end
      end
    end
  endfunction

  // expected result of one item, updating the local table
  function automatic emt_pkg::out_t translate_block(emt_pkg::in_t it);
    emt_pkg::out_t r;
    bit            hit;
    int            pos;
    logic [31:0]   end_l;
    r = '0;
    hit = 1'b0;
    if (it.action == emt_pkg::ActClear) begin
      tbl_count = 0;
      r.status = emt_pkg::StDone;
    end else if (it.action == emt_pkg::ActSet) begin
      if (it.run_length == 16'd0) begin
        r.status = emt_pkg::StBadLen;
      end else begin
        tbl_start[0] = it.logical_block;
        tbl_phys[0]  = it.physical_in;
        tbl_len[0]   = it.run_length;
        tbl_count    = 1;
        r.status     = emt_pkg::StDone;
      end
    end else begin
      for (int i = tbl_count - 1; i >= 0; i--) begin
        end_l = tbl_start[i] + 32'(tbl_len[i]);
        if (tbl_len[i] != 0 && it.logical_block >= tbl_start[i] &&
            it.logical_block < end_l) begin
          r.physical_block = tbl_phys[i] + 16'(it.logical_block - tbl_start[i]);
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        r.status = emt_pkg::StHit;
      end else if (it.action == emt_pkg::ActLookup) begin
        r.status = emt_pkg::StUnmapped;
      end else if (!it.alloc_ok) begin
        r.status = emt_pkg::StNoBlock;
      end else if (tbl_count == 1 &&
                   it.logical_block == tbl_start[0] + 32'(tbl_len[0]) &&
                   it.physical_in == tbl_phys[0] + tbl_len[0]) begin
        tbl_len[0]++;
        r.physical_block = it.physical_in;
        r.status = emt_pkg::StMapped;
      end else if (tbl_count >= NumExt) begin
        r.status = emt_pkg::StFull;
      end else begin
        pos = tbl_count;
        for (int i = 0; i < tbl_count; i++) begin
          if (it.logical_block < tbl_start[i]) begin
            pos = i;
            break;
          end
        end
        for (int k = tbl_count; k > pos; k--) begin
          tbl_start[k] = tbl_start[k-1];
          tbl_phys[k]  = tbl_phys[k-1];
          tbl_len[k]   = tbl_len[k-1];
        end
        tbl_start[pos] = it.logical_block;
        tbl_phys[pos]  = it.physical_in;
        tbl_len[pos]   = 16'd1;
        tbl_count++;
        merge_runs();
        r.physical_block = it.physical_in;
        r.status = emt_pkg::StMapped;
      end
    end
    r.extents_used = 7'(tbl_count);
    return r;
  endfunction

  function automatic emt_pkg::in_t make_item(logic [1:0] act, logic [31:0] lb,
                                             logic [15:0] pin, logic aok,
                                             logic [15:0] rlen);
    emt_pkg::in_t it;
    it.action = act;
    it.logical_block = lb;
    it.physical_in = pin;
    it.alloc_ok = aok;
    it.run_length = rlen;
    return it;
  endfunction

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: one item at a time from the queue, random gap before each
  int in_gap;
  initial begin
    in_valid = 1'b0;
    in_item  = '0;
    in_gap   = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(translate_block(in_item));
        sent_items++;
      end
      if (!in_valid || in_ready) begin
        // the slot is free at this edge
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          // a zero gap now and then keeps back-to-back items common
          in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls on the result side, checks each accepted item
  int out_stall;
  initial begin
    out_ready = 1'b0;
    out_stall = 0;
  end

  always @(posedge clk) begin
    emt_pkg::out_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing expected: %h", out_item);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.physical_block !== out_item.physical_block ||
              exp_r.status !== out_item.status ||
              exp_r.extents_used !== out_item.extents_used) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected phys %h status %0d used %0d, %s %h %0d %0d",
                       exp_r.physical_block, exp_r.status, exp_r.extents_used,
                       "got phys/status/used",
                       out_item.physical_block, out_item.status, out_item.extents_used);
          end
        end
        out_stall <= $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] base;
    logic [15:0] pbase;
    int          n;
    mismatches = 0;
    results_seen = 0;
    sent_items = 0;
    stim_done = 1'b0;

    // directed: misses on empty table, extremes, every action and status
    pending_items.push_back(make_item(emt_pkg::ActLookup, 32'h0, 16'h0, 1'b0, 16'h0));
    pending_items.push_back(make_item(emt_pkg::ActCreate, 32'hFFFF_FFFF, 16'hFFFF, 1'b0,
                                      16'hFFFF));
    pending_items.push_back(make_item(emt_pkg::ActSet, 32'h10, 16'h20, 1'b1, 16'h0));
    pending_items.push_back(make_item(emt_pkg::ActSet, 32'h10, 16'hFFF0, 1'b0, 16'h20));
    pending_items.push_back(make_item(emt_pkg::ActLookup, 32'h2F, 16'h0, 1'b0, 16'h0));
    pending_items.push_back(make_item(emt_pkg::ActLookup, 32'h30, 16'h0, 1'b0, 16'h0));
    // extend the single extent, then hit the block just added
    pending_items.push_back(make_item(emt_pkg::ActCreate, 32'h30, 16'h0010, 1'b1, 16'h0));
    pending_items.push_back(make_item(emt_pkg::ActCreate, 32'h30, 16'h1234, 1'b1, 16'h0));
    // insert before, then an adjacent pair that merges
    pending_items.push_back(make_item(emt_pkg::ActCreate, 32'h5, 16'h500, 1'b1, 16'h0));
    pending_items.push_back(make_item(emt_pkg::ActCreate, 32'h6, 16'h501, 1'b1, 16'h0));
    pending_items.push_back(make_item(emt_pkg::ActCreate, 32'h4, 16'h4FF, 1'b1, 16'h0));
    pending_items.push_back(make_item(emt_pkg::ActLookup, 32'h6, 16'h0, 1'b0, 16'h0));
    // length wrapping to zero: full-length single extent extended once
    pending_items.push_back(make_item(emt_pkg::ActSet, 32'hFFFF_0000, 16'h0, 1'b1,
                                      16'hFFFF));
    pending_items.push_back(make_item(emt_pkg::ActCreate, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                      16'h0));
    pending_items.push_back(make_item(emt_pkg::ActLookup, 32'hFFFF_0001, 16'h0, 1'b0,
                                      16'h0));
    pending_items.push_back(make_item(emt_pkg::ActCreate, 32'hFFFF_0001, 16'h7, 1'b1,
                                      16'h0));
    pending_items.push_back(make_item(emt_pkg::ActClear, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                      16'hFFFF));
    pending_items.push_back(make_item(emt_pkg::ActLookup, 32'hFFFF_0001, 16'h0, 1'b0,
                                      16'h0));
    // fill to full: scattered one-block extents
    for (int i = 0; i < NumExt + 2; i++)
      pending_items.push_back(make_item(emt_pkg::ActCreate, 32'(i * 3), 16'(i * 7), 1'b1,
                                        16'h0));
    pending_items.push_back(make_item(emt_pkg::ActLookup, 32'h3, 16'h0, 1'b0, 16'h0));

    // random: runs of creates in small windows so hits, merges and full occur
    while (pending_items.size() + sent_items < 450) begin
      case ($urandom_range(0, 9))
        0: pending_items.push_back(make_item(emt_pkg::ActClear, $urandom, 16'($urandom),
                                             1'($urandom), 16'($urandom)));
        1: pending_items.push_back(make_item(emt_pkg::ActSet, $urandom, 16'($urandom),
                                             1'($urandom),
                                             ($urandom_range(0, 4) == 0) ? 16'h0
                                                                         : 16'($urandom)));
        2: pending_items.push_back(make_item(2'($urandom), $urandom, 16'($urandom),
                                             1'($urandom), 16'($urandom)));
        default: begin
          base  = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 255)) : $urandom;
          pbase = 16'($urandom);
          n = $urandom_range(4, 30);
          for (int i = 0; i < n; i++) begin
            logic [7:0] off;
            off = 8'($urandom_range(0, 40));
            pending_items.push_back(make_item(($urandom_range(0, 4) == 0)
                                                ? emt_pkg::ActLookup
                                                : emt_pkg::ActCreate,
                                              base + 32'(off),
                                              ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                          : pbase + 16'(off),
                                              ($urandom_range(0, 7) != 0), 16'($urandom)));
          end
        end
      endcase
    end

    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("ran %0d items through lookup, create, clear and set-single, %0d results checked",
             sent_items, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/emt_pkg.sv
rtl/emt_cell.sv
rtl/extent_map_table_top.sv
tb/sv/tb_extent_map_table_top.sv
